FILE: hw/rtl/uqp_pkg.sv
// Shared types and constants for the URL query parameter parser.
package uqp_pkg;

  localparam int DELIM_REGS = 4;
  localparam int MAX_DELIMITERS = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam logic [7:0] CHAR_QUERY = 8'h3F;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic OP_PARSE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [2:0] REG_DELIM_COUNT = 3'd0;
  localparam logic [2:0] REG_DELIM_A     = 3'd1;
  localparam logic [2:0] REG_DELIM_B     = 3'd2;
  localparam logic [2:0] REG_DELIM_C     = 3'd3;
  localparam logic [2:0] REG_DELIM_D     = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_MANY  = 2'd1;
  localparam logic [1:0] STATUS_NAME_OVF  = 2'd2;
  localparam logic [1:0] STATUS_VALUE_OVF = 2'd3;

  typedef enum logic [2:0] {
    KIND_END,
    KIND_QUERY,
    KIND_EQUAL,
    KIND_AMP,
    KIND_DELIM,
    KIND_CHAR
  } byte_kind_t;

  typedef struct packed {
    logic       operation;
    byte_kind_t kind;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [2:0] read_index;
  } entry_t;

endpackage

FILE: hw/rtl/uqp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/uqp_front.sv
// Front end: request intake, delimiter registers and byte classification.
module uqp_front import uqp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       operation,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [2:0] read_index,
  input  logic       write_enable,
  input  logic [2:0] register_index,
  input  logic [7:0] write_data,
  input  logic       full,
  output logic       push,
  output entry_t     push_entry
);

  logic [2:0] delimiter_count;
  logic [7:0] delimiter [DELIM_REGS];
  logic [2:0] delim_used;
  logic       delim_hit;
  byte_kind_t kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_count <= '0;
      for (int i = 0; i < DELIM_REGS; i++) begin
        delimiter[i] <= '0;
      end
    end else if (write_enable) begin
      unique case (register_index)
        REG_DELIM_COUNT: delimiter_count <= write_data[2:0];
        REG_DELIM_A:     delimiter[0] <= write_data;
        REG_DELIM_B:     delimiter[1] <= write_data;
        REG_DELIM_C:     delimiter[2] <= write_data;
        REG_DELIM_D:     delimiter[3] <= write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    delim_used = (delimiter_count > 3'(MAX_DELIMITERS)) ? 3'(MAX_DELIMITERS) : delimiter_count;
    delim_hit = 1'b0;
    for (int i = 0; i < DELIM_REGS; i++) begin
      if ((3'(i) < delim_used) && (delimiter[i] == data_byte)) begin
        delim_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
      kind = KIND_END;
    end else if (data_byte == CHAR_QUERY) begin
      kind = KIND_QUERY;
    end else if (data_byte == CHAR_EQUAL) begin
      kind = KIND_EQUAL;
    end else if (data_byte == CHAR_AMP) begin
      kind = KIND_AMP;
    end else if (delim_hit) begin
      kind = KIND_DELIM;
    end else begin
      kind = KIND_CHAR;
    end
  end

  assign item_stall = full;
  assign push       = item_valid && !full;

  assign push_entry = '{operation:  operation,
                        kind:       kind,
                        data_byte:  data_byte,
                        last_byte:  last_byte,
                        read_index: read_index};

endmodule

FILE: hw/rtl/uqp_queue.sv
// Short request queue between the front end and the back end.
module uqp_queue import uqp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  entry_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/uqp_back.sv
// Back end: parse state, value store, value readout and result register.
module uqp_back import uqp_pkg::*; #(
  parameter int SLOT_COUNT   = 8,
  parameter int NAME_LENGTH  = 16,
  parameter int VALUE_LENGTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       empty,
  output logic       pop,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] status,
  output logic [3:0] param_count,
  output logic       parse_done,
  output logic [7:0] value_char,
  output logic       last
);

  localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int POS_W    = (VALUE_LENGTH > 1) ? $clog2(VALUE_LENGTH) : 1;
  localparam int FILL_W   = $clog2(VALUE_LENGTH + 1);
  localparam int MAX_LEN  = (NAME_LENGTH > VALUE_LENGTH) ? NAME_LENGTH : VALUE_LENGTH;
  localparam int CHAR_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W   = SLOT_W + POS_W;
  localparam int RAM_SIZE = 1 << ADDR_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state, state_next;
  logic              mid_message, mid_message_next;
  logic              query_started, query_started_next;
  logic              in_value, in_value_next;
  logic [CHAR_W-1:0] char_position, char_position_next;
  logic [SLOT_W-1:0] slot_index, slot_index_next;
  logic              finished, finished_next;
  logic [1:0]        error_status, error_status_next;
  logic [FILL_W-1:0] cur_fill, cur_fill_next;
  logic [FILL_W-1:0] fill [SLOT_COUNT];
  logic              fill_clear;
  logic              fill_we;

  logic [SLOT_W-1:0] rd_slot, rd_slot_next;
  logic [FILL_W-1:0] rd_fill, rd_fill_next;
  logic [FILL_W-1:0] rd_pos, rd_pos_next;
  logic [7:0]        pending, pending_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              out_free;
  logic              emit;
  logic [7:0]        emit_char;
  logic              emit_last;

  uqp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_SIZE)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    logic [SLOT_W:0]   slot_plus;
    logic [CHAR_W-1:0] pos_inc;
    logic              term;

    state_next         = state;
    mid_message_next   = mid_message;
    query_started_next = query_started;
    in_value_next      = in_value;
    char_position_next = char_position;
    slot_index_next    = slot_index;
    finished_next      = finished;
    error_status_next  = error_status;
    cur_fill_next      = cur_fill;
    fill_clear         = 1'b0;
    fill_we            = 1'b0;
    rd_slot_next       = rd_slot;
    rd_fill_next       = rd_fill;
    rd_pos_next        = rd_pos;
    pending_next       = pending;
    ram_we             = 1'b0;
    ram_waddr          = {slot_index, char_position[POS_W-1:0]};
    ram_re             = 1'b0;
    ram_raddr          = {rd_slot, rd_pos[POS_W-1:0]};
    pop                = 1'b0;
    emit               = 1'b0;
    emit_char          = '0;
    emit_last          = 1'b1;
    slot_plus          = '0;
    pos_inc            = char_position + 1'b1;
    term               = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (!empty && out_free) begin
          pop = 1'b1;
          if (head.operation == OP_PARSE) begin
            // first byte of a message starts from a clean slate
            if (!mid_message) begin
              query_started_next = 1'b0;
              in_value_next      = 1'b0;
              char_position_next = '0;
              slot_index_next    = '0;
              finished_next      = 1'b0;
              error_status_next  = STATUS_OK;
              cur_fill_next      = '0;
              fill_clear         = 1'b1;
            end
            slot_plus = {1'b0, slot_index_next} + 1'b1;
            pos_inc   = char_position_next + 1'b1;
            ram_waddr = {slot_index_next, char_position_next[POS_W-1:0]};
            if (!finished_next) begin
              unique case (head.kind)
                KIND_END: finished_next = 1'b1;
                KIND_QUERY: query_started_next = 1'b1;
                KIND_EQUAL: begin
                  char_position_next = '0;
                  in_value_next      = 1'b1;
                end
                KIND_AMP: begin
                  if (slot_plus >= (SLOT_W + 1)'(SLOT_COUNT)) begin
                    error_status_next = STATUS_TOO_MANY;
                    finished_next     = 1'b1;
                  end else begin
                    slot_index_next    = slot_plus[SLOT_W-1:0];
                    char_position_next = '0;
                    in_value_next      = 1'b0;
                    cur_fill_next      = '0;
                  end
                end
                KIND_DELIM: begin
                  if (query_started_next) begin
                    finished_next = 1'b1;
                  end
                end
                KIND_CHAR: begin
                  if (query_started_next) begin
                    if (in_value_next) begin
                      if (char_position_next < CHAR_W'(VALUE_LENGTH)) begin
                        ram_we             = 1'b1;
                        fill_we            = 1'b1;
                        char_position_next = pos_inc;
                        if (FILL_W'(pos_inc) > cur_fill_next) begin
                          cur_fill_next = FILL_W'(pos_inc);
                        end
                      end else begin
                        error_status_next = STATUS_VALUE_OVF;
                        finished_next     = 1'b1;
                      end
                    end else begin
                      if (char_position_next < CHAR_W'(NAME_LENGTH)) begin
                        char_position_next = pos_inc;
                      end else begin
                        error_status_next = STATUS_NAME_OVF;
                        finished_next     = 1'b1;
                      end
                    end
                  end
                end
                default: ;
              endcase
            end
            mid_message_next = !head.last_byte;
            emit             = 1'b1;
          end else begin
            rd_slot_next = SLOT_W'(head.read_index);
            rd_fill_next = (5'(head.read_index) < 5'(SLOT_COUNT)) ?
                           fill[SLOT_W'(head.read_index)] : '0;
            rd_pos_next  = '0;
            ram_re       = 1'b1;
            ram_raddr    = {SLOT_W'(head.read_index), POS_W'(0)};
            state_next   = ST_READ;
          end
        end
      end
      ST_READ: begin
        // one character of lookahead so the final one carries last
        if (out_free) begin
          term = (rd_pos >= rd_fill) || (ram_rdata == '0);
          if (term) begin
            emit       = 1'b1;
            emit_char  = (rd_pos == '0) ? 8'h00 : pending;
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            pending_next = ram_rdata;
            if (rd_pos != '0) begin
              emit      = 1'b1;
              emit_char = pending;
              emit_last = 1'b0;
            end
            rd_pos_next = rd_pos + 1'b1;
            ram_re      = 1'b1;
            ram_raddr   = {rd_slot, rd_pos_next[POS_W-1:0]};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mid_message   <= 1'b0;
      query_started <= 1'b0;
      in_value      <= 1'b0;
      char_position <= '0;
      slot_index    <= '0;
      finished      <= 1'b0;
      error_status  <= STATUS_OK;
      cur_fill      <= '0;
      result_valid  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        fill[i] <= '0;
      end
    end else begin
      state         <= state_next;
      mid_message   <= mid_message_next;
      query_started <= query_started_next;
      in_value      <= in_value_next;
      char_position <= char_position_next;
      slot_index    <= slot_index_next;
      finished      <= finished_next;
      error_status  <= error_status_next;
      cur_fill      <= cur_fill_next;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (fill_we && (slot_index_next == SLOT_W'(i))) begin
          fill[i] <= cur_fill_next;
        end else if (fill_clear) begin
          fill[i] <= '0;
        end
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_slot_next;
    rd_fill <= rd_fill_next;
    rd_pos  <= rd_pos_next;
    pending <= pending_next;
    if (emit) begin
      status      <= error_status_next;
      param_count <= 4'({1'b0, slot_index_next} + 1'b1);
      parse_done  <= finished_next;
      value_char  <= emit_char;
      last        <= emit_last;
    end
  end

  a_error_ends_parse: assert property (@(posedge clk) disable iff (rst)
    (error_status != STATUS_OK) |-> finished)
    else $error("error status set while parse still running");

  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
    (finished && mid_message) |=> (finished && $stable(error_status) && $stable(slot_index)))
    else $error("parse state changed after end within a message");

  a_read_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> ((rd_fill <= FILL_W'(VALUE_LENGTH)) && (rd_pos <= rd_fill)))
    else $error("readout position beyond stored value");

  a_no_pop_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !pop)
    else $error("request taken from queue during readout");

endmodule

FILE: hw/rtl/url_query_parameter_parser.sv
// Top level of the URL query parameter parser: front end, request queue, back end.
// Parse requests run at one per cycle while the result output is not stalled; a read of a
// value holds the back end until fully read out, one RAM read per unstalled cycle plus lookahead.
// A four-entry queue lets the input keep accepting while the back end streams or stalls.
// Reset (synchronous, active high) clears parse state, fill counts and delimiter registers.
module url_query_parameter_parser import uqp_pkg::*; #(
  parameter int SLOT_COUNT   = 8,
  parameter int NAME_LENGTH  = 16,
  parameter int VALUE_LENGTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_enable,
  input  logic [2:0] register_index,
  input  logic [7:0] write_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       operation,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [2:0] read_index,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] status,
  output logic [3:0] param_count,
  output logic       parse_done,
  output logic [7:0] value_char,
  output logic       last
);

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t head;
  logic   empty;

  uqp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .read_index     (read_index),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .full           (full),
    .push           (push),
    .push_entry     (push_entry)
  );

  uqp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  uqp_back #(
    .SLOT_COUNT   (SLOT_COUNT),
    .NAME_LENGTH  (NAME_LENGTH),
    .VALUE_LENGTH (VALUE_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .param_count  (param_count),
    .parse_done   (parse_done),
    .value_char   (value_char),
    .last         (last)
  );

endmodule

FILE: tb/url_query_parameter_parser_test.sv
// Self-checking testbench for the URL query parameter parser: directed and random requests.
module url_query_parameter_parser_test import uqp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int NAME_LEN = 16;
  localparam int VALUE_LEN = 32;
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_REQUESTS = 95;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [2:0] read_index;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] param_count;
    logic       parse_done;
    logic [7:0] value_char;
    logic       last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       write_enable = 1'b0;
  logic [2:0] register_index = REG_DELIM_COUNT;
  logic [7:0] write_data = 8'h00;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       operation = OP_PARSE;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic [2:0] read_index = 3'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] status;
  logic [3:0] param_count;
  logic       parse_done;
  logic [7:0] value_char;
  logic       last;

  url_query_parameter_parser #(
    .SLOT_COUNT  (SLOTS),
    .NAME_LENGTH (NAME_LEN),
    .VALUE_LENGTH(VALUE_LEN)
  ) DUT (.*);

  // parser mirror
  logic [7:0] value_mem [SLOTS*VALUE_LEN];
  logic       query_seen, in_value, query_done, mid_msg;
  int         char_pos, slot;
  logic [1:0] err_code;
  logic [2:0] delim_count_cfg;
  logic [7:0] delim_cfg [4];

  request_t   pending_requests [$];
  result_t    expected_results [$];
  request_t   offered;
  int         phase_items;
  int         errors = 0;
  int         results_seen = 0;
  int         hold_left = 0;
  bit         hold_done = 0;
  bit         no_gaps = 0;
  int         stuck_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_query();
    foreach (value_mem[i]) value_mem[i] = 8'h00;
    query_seen = 0;
    in_value = 0;
    query_done = 0;
    char_pos = 0;
    slot = 0;
    err_code = STATUS_OK;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    int n;
    n = (delim_count_cfg > MAX_DELIMITERS) ? MAX_DELIMITERS : delim_count_cfg;
    for (int i = 0; i < n; i++)
      if (delim_cfg[i] == c) return 1;
    return 0;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    bit skip;
    skip = 0;
    if (c == CHAR_LF || c == CHAR_CR) begin
      query_done = 1;
      return;
    end
    if (c == CHAR_QUERY) begin
      query_seen = 1;
      skip = 1;
    end else if (c == CHAR_EQUAL) begin
      char_pos = 0;
      in_value = 1;
      skip = 1;
    end else if (c == CHAR_AMP) begin
      if (slot + 1 >= SLOTS) begin
        err_code = STATUS_TOO_MANY;
        query_done = 1;
        return;
      end
      slot++;
      char_pos = 0;
      in_value = 0;
      skip = 1;
    end
    if (!query_seen || skip) return;
    if (is_delim(c)) begin
      query_done = 1;
      return;
    end
    if (in_value) begin
      if (char_pos < VALUE_LEN) begin
        value_mem[slot*VALUE_LEN + char_pos] = c;
        char_pos++;
      end else begin
        err_code = STATUS_VALUE_OVF;
        query_done = 1;
      end
    end else begin
      if (char_pos < NAME_LEN) begin
        char_pos++;
      end else begin
        err_code = STATUS_NAME_OVF;
        query_done = 1;
      end
    end
  endfunction

  function automatic void add_expected(logic [7:0] ch, logic is_last);
    result_t r;
    r.status = err_code;
    r.param_count = 4'(slot + 1);
    r.parse_done = query_done;
    r.value_char = ch;
    r.last = is_last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(request_t q);
    int base, n;
    if (q.operation == OP_PARSE) begin
      if (!mid_msg) begin
        clear_query();
        mid_msg = 1;
      end
      if (!query_done) parse_char(q.data_byte);
      if (q.last_byte) mid_msg = 0;
      add_expected(8'h00, 1'b1);
    end else begin
      base = int'(q.read_index) * VALUE_LEN;
      n = 0;
      while (n < VALUE_LEN && value_mem[base + n] != 8'h00) n++;
      if (n == 0) add_expected(8'h00, 1'b1);
      for (int i = 0; i < n; i++) add_expected(value_mem[base + i], i == n - 1);
    end
  endfunction

  // stimulus building
  function automatic void add_parse(logic [7:0] c, logic close);
    request_t q;
    q.operation = OP_PARSE;
    q.data_byte = c;
    q.last_byte = close;
    q.read_index = 3'($urandom_range(7));
    pending_requests.push_back(q);
    phase_items++;
  endfunction

  function automatic void add_read(int idx);
    request_t q;
    q.operation = OP_READ;
    q.data_byte = 8'($urandom_range(255));
    q.last_byte = 1'($urandom_range(1));
    q.read_index = 3'(idx);
    pending_requests.push_back(q);
    phase_items++;
  endfunction

  function automatic void add_text(string s, logic close);
    for (int i = 0; i < s.len(); i++) add_parse(s[i], close && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 8'($urandom_range(97, 122));
    if (r < 95) return 8'($urandom_range(48, 57));
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_random_message();
    logic [7:0] msg [$];
    int kind, params, len, used;
    kind = $urandom_range(99);
    if (kind < 12) begin
      len = $urandom_range(1, 12);
      repeat (len) msg.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(1)) begin
        msg.push_back("/");
        repeat ($urandom_range(1, 4)) msg.push_back(text_char());
      end
      // a few messages lose their query mark
      if (kind >= 20) msg.push_back(CHAR_QUERY);
      params = ($urandom_range(9) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 4);
      for (int p = 0; p < params; p++) begin
        len = ($urandom_range(11) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
        repeat (len) msg.push_back(text_char());
        if ($urandom_range(9) != 0) begin
          msg.push_back(CHAR_EQUAL);
          len = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
          repeat (len) msg.push_back(text_char());
        end
        if (p < params - 1) msg.push_back(CHAR_AMP);
      end
      case ($urandom_range(4))
        1: msg.push_back(CHAR_CR);
        2: msg.push_back(CHAR_LF);
        3: begin
          used = (delim_count_cfg > MAX_DELIMITERS) ? MAX_DELIMITERS : delim_count_cfg;
          if (used > 0) msg.push_back(delim_cfg[$urandom_range(used - 1)]);
        end
        4: begin
          msg.push_back(CHAR_CR);
          msg.push_back(CHAR_LF);
        end
        default: ;
      endcase
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(255)));
    end
    if (msg.size() == 0) msg.push_back(text_char());
    foreach (msg[i]) begin
      if ($urandom_range(39) == 0) add_read($urandom_range(7));
      add_parse(msg[i], i == msg.size() - 1);
    end
    repeat ($urandom_range(1, 3)) add_read($urandom_range(7));
  endfunction

  task automatic drain();
    while (pending_requests.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] value);
    @(posedge clk);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= value;
    if (idx == REG_DELIM_COUNT) delim_count_cfg = value[2:0];
    else delim_cfg[idx - REG_DELIM_A] = value;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic run_random();
    @(negedge clk);
    phase_items = 0;
    while (phase_items < PHASE_REQUESTS) add_random_message();
    drain();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) predict_request(offered);
      if (!item_valid || !item_stall) begin
        if (pending_requests.size() > 0 && (no_gaps || $urandom_range(99) >= 37)) begin
          offered = pending_requests.pop_front();
          item_valid <= 1'b1;
          operation <= offered.operation;
          data_byte <= offered.data_byte;
          last_byte <= offered.last_byte;
          read_index <= offered.read_index;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("unexpected result: value_char %0h", value_char);
      errors++;
    end else begin
      want = expected_results.pop_front();
      check_field("status", want.status, status);
      check_field("param_count", want.param_count, param_count);
      check_field("parse_done", want.parse_done, parse_done);
      check_field("value_char", want.value_char, value_char);
      check_field("last", want.last, last);
    end
  endfunction

  // result monitor, with one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result();
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= 150) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      result_stall <= (hold_left > 0) || (!no_gaps && $urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    clear_query();
    mid_msg = 0;
    delim_count_cfg = 3'd0;
    foreach (delim_cfg[i]) delim_cfg[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default registers: no delimiters, so a zero byte is stored
    @(negedge clk);
    add_text("a=b&?c=d", 1);
    add_read(0);
    add_read(1);
    add_text("?p=", 0);
    add_parse(8'h00, 0);
    add_text("z", 0);
    add_parse(CHAR_LF, 0);
    add_text("qq", 1);
    add_read(0);
    add_text("?&&&&&&&&", 1);
    add_read(7);
    drain();

    write_reg(REG_DELIM_COUNT, 8'd4);
    write_reg(REG_DELIM_A, "#");
    write_reg(REG_DELIM_B, ";");
    write_reg(REG_DELIM_C, 8'h00);
    write_reg(REG_DELIM_D, 8'hFF);
    @(negedge clk);
    add_text("?a=1#b", 1);
    add_text("?k=", 0);
    add_parse(8'h00, 1);
    add_text("?x=y", 0);
    add_parse(8'hFF, 1);
    add_read(0);
    run_random();

    write_reg(REG_DELIM_COUNT, 8'd0);
    run_random();

    // count above the register set is clamped
    write_reg(REG_DELIM_COUNT, 8'd7);
    write_reg(REG_DELIM_A, 8'($urandom_range(255)));
    write_reg(REG_DELIM_B, 8'($urandom_range(97, 122)));
    write_reg(REG_DELIM_C, 8'($urandom_range(48, 57)));
    write_reg(REG_DELIM_D, 8'($urandom_range(255)));
    no_gaps = 1;
    run_random();
    no_gaps = 0;

    write_reg(REG_DELIM_COUNT, 8'd2);
    write_reg(REG_DELIM_A, "a");
    write_reg(REG_DELIM_B, 8'($urandom_range(255)));
    run_random();

    repeat (20) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
